@@ hw/rtl/sfms_pkg.sv @@
// Shared constants and types for the substring first-match search block.
// Used by sfms_cell and substring_first_match_search; depends on nothing else.
package sfms_pkg;

   // Default build parameters.
   localparam int PATTERN_MAX_DEFAULT    = 16;
   localparam int POSITION_WIDTH_DEFAULT = 32;

   // Fixed field widths.
   localparam int BYTE_WIDTH       = 8;
   localparam int PATTERN_WORD_W   = 64;
   localparam int LENGTH_REG_WIDTH = 5;
   localparam int OFFSET_WIDTH     = 32;
   localparam int MATCH_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 64;

   typedef logic [BYTE_WIDTH-1:0]      src_byte_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_PATTERN_LOW  = csr_index_type'(0);
   localparam csr_index_type CSR_PATTERN_HIGH = csr_index_type'(1);
   localparam csr_index_type CSR_PATTERN_LEN  = csr_index_type'(2);
   localparam csr_index_type CSR_START_OFFSET = csr_index_type'(3);

endpackage

@@ hw/rtl/sfms_cell.sv @@
// One window cell: holds one recent source byte, passes it on to the next
// cell on every request and compares the incoming byte against its pattern byte.
// Depends on sfms_pkg.
module sfms_cell
   import sfms_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   parameter int CELL_INDEX  = 0,
   parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  logic                                  clock,
   input  logic                                  shift_en,
   input  src_byte_type                          byte_in,
   input  logic [PATTERN_MAX-1:0][BYTE_WIDTH-1:0] pattern_bytes,
   input  logic [LEN_W-1:0]                      len,
   output src_byte_type                          byte_out,
   output logic                                  match
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(CELL_INDEX);

   src_byte_type     byte_ff;
   logic             active;
   logic [LEN_W-1:0] sel_full;
   logic [IDX_W-1:0] sel;

   // The byte entering this cell lines up with pattern byte len-1-CELL_INDEX.
   assign active   = CELL_POS < len;
   assign sel_full = len - CELL_POS - LEN_W'(1);
   assign sel      = sel_full[IDX_W-1:0];
   assign match    = !active || (byte_in == pattern_bytes[sel]);

   // Window storage moves one place down the chain per request.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

@@ hw/rtl/substring_first_match_search.sv @@
// Latency: a result is registered at the edge that accepts the byte that causes it,
// and is presented on the rsp_ port from the next cycle.
// Throughput: one source byte per cycle; req_stall rises only while a result waits
// on a stalled rsp_ port, as the single output register is then full.
// Reset: configuration registers and string state clear at once; no clearing pass.
// The compare of the window cells and the position add are both combinational.
module substring_first_match_search
   import sfms_pkg::*;
#(
   parameter int PATTERN_MAX    = PATTERN_MAX_DEFAULT,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_WIDTH-1:0]      req_source_byte,
   input  logic                       req_final_byte,
   // Result channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [MATCH_WIDTH-1:0]     rsp_match_start,
   // Configuration port.
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int PW    = POSITION_WIDTH;

   // Configuration registers.
   logic [PATTERN_WORD_W-1:0]   pattern_low_ff;
   logic [PATTERN_WORD_W-1:0]   pattern_high_ff;
   logic [LENGTH_REG_WIDTH-1:0] pattern_length_ff;
   logic [OFFSET_WIDTH-1:0]     start_offset_ff;

   // String state.
   logic [PW-1:0] bytes_seen_ff;
   logic [PW-1:0] bytes_seen_in;
   logic          match_reported_ff;
   logic          match_reported_in;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_found_ff;
   logic                   rsp_found_in;
   logic [MATCH_WIDTH-1:0] rsp_match_start_ff;
   logic [MATCH_WIDTH-1:0] rsp_match_start_in;

   logic                                   req_accept;
   logic                                   rsp_accept;
   logic [2*PATTERN_WORD_W-1:0]            pattern_all;
   logic [PATTERN_MAX-1:0][BYTE_WIDTH-1:0] pattern_bytes;
   logic [LEN_W-1:0]                       len;
   logic [PATTERN_MAX-1:0][BYTE_WIDTH-1:0] cell_byte;
   logic [PATTERN_MAX-1:0]                 cell_match;
   logic [PW-1:0]                          seen_next;
   logic                                   hit;
   logic [PW-1:0]                          position;

   // Handshakes: the output register frees itself in the cycle it is taken.
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
         start_offset_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_write_data[LENGTH_REG_WIDTH-1:0];
            CSR_START_OFFSET: start_offset_ff   <= csr_write_data[OFFSET_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Pattern bytes in use and the saturated pattern length.
   assign pattern_all = {pattern_high_ff, pattern_low_ff};
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pattern_bytes[k] = pattern_all[k*BYTE_WIDTH +: BYTE_WIDTH];
      end
   end
   assign len = (pattern_length_ff > LENGTH_REG_WIDTH'(PATTERN_MAX))
                ? LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_ff);

   // Chain of window cells; cell 0 takes the new byte.
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      src_byte_type byte_in;
      if (j == 0) begin : g_head
         assign byte_in = req_source_byte;
      end else begin : g_body
         assign byte_in = cell_byte[j-1];
      end
      sfms_cell #(
         .PATTERN_MAX (PATTERN_MAX),
         .CELL_INDEX  (j),
         .LEN_W       (LEN_W)
      ) u_cell (
         .clock         (clock),
         .shift_en      (req_accept),
         .byte_in       (byte_in),
         .pattern_bytes (pattern_bytes),
         .len           (len),
         .byte_out      (cell_byte[j]),
         .match         (cell_match[j])
      );
   end

   // Match check over the window as it stands after this byte.
   assign seen_next = (bytes_seen_ff == '1) ? bytes_seen_ff : bytes_seen_ff + PW'(1);
   assign hit       = (len != '0) && (seen_next >= PW'(len)) && (&cell_match);
   assign position  = start_offset_ff[PW-1:0] + seen_next - PW'(len);

   // Next string state and result.
   always_comb begin
      bytes_seen_in      = bytes_seen_ff;
      match_reported_in  = match_reported_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_accept;
      rsp_found_in       = rsp_found_ff;
      rsp_match_start_in = rsp_match_start_ff;
      if (req_accept) begin
         if (match_reported_ff) begin
            // Rest of a string that already matched is dropped.
            if (req_final_byte) begin
               bytes_seen_in     = '0;
               match_reported_in = 1'b0;
            end
         end else begin
            bytes_seen_in = seen_next;
            if (hit) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b1;
               rsp_match_start_in = MATCH_WIDTH'(position);
               if (req_final_byte) begin
                  bytes_seen_in = '0;
               end else begin
                  match_reported_in = 1'b1;
               end
            end else if (req_final_byte) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b0;
               rsp_match_start_in = '0;
               bytes_seen_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff       <= rsp_found_in;
      rsp_match_start_ff <= rsp_match_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_start = rsp_match_start_ff;

   // A stalled request side means a result is waiting.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no pending result");

   // A not-found result carries a zero position.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_start == '0))
      else $error("not-found result with nonzero position");

   // The last byte of a string always leaves clean string state.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_final_byte)
      |=> (bytes_seen_ff == '0) && !match_reported_ff)
      else $error("string state not cleared after last byte");

   // The matched flag only rises together with a found result.
   a_reported_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(match_reported_ff) |-> (rsp_valid && rsp_found))
      else $error("match flag set without a found result");

endmodule
